@@ rtl/core/ptt_pkg.sv @@
// Package for the periodic timer table: codes, slot record and update types.
// Used by ptt_slot_alu and periodic_timer_table.
`default_nettype none

package ptt_pkg;

  // Field widths of the stream beats
  localparam int KIND_W  = 2;
  localparam int ID_W    = 4;
  localparam int CNT_W   = 16;
  localparam int EV_W    = 3;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  // Input item kinds; the fourth code is ignored
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNREG = 2'd2;

  // Result codes
  localparam logic [EV_W-1:0] EV_REGISTERED = 3'd0;
  localparam logic [EV_W-1:0] EV_DUPLICATE  = 3'd1;
  localparam logic [EV_W-1:0] EV_REMOVED    = 3'd2;
  localparam logic [EV_W-1:0] EV_NOT_FOUND  = 3'd3;
  localparam logic [EV_W-1:0] EV_FIRED      = 3'd4;
  localparam logic [EV_W-1:0] EV_FIRED_LAST = 3'd5;
  localparam logic [EV_W-1:0] EV_QUIET      = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_PUSH,
    ST_DONE
  } state_t;

  // One slot entry of the timer memory
  typedef struct packed {
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] elapsed;
    logic [CNT_W-1:0] loops;
  } slot_rec_t;

  // Outcome of advancing one slot by one tick
  typedef struct packed {
    logic [CNT_W-1:0] elapsed;
    logic [CNT_W-1:0] loops;
    logic             fired;
    logic             final_fire;
    logic             keep;
  } upd_t;

endpackage

`default_nettype wire

@@ rtl/core/ptt_slot_alu.sv @@
// Shared tick update unit: advances one slot record by one tick.
// Depends on ptt_pkg for the slot record and update types.
`default_nettype none

module ptt_slot_alu (
  input  ptt_pkg::slot_rec_t rec,
  output ptt_pkg::upd_t      upd
);

  logic [ptt_pkg::CNT_W-1:0] elapsed_inc;
  logic [ptt_pkg::CNT_W-1:0] loops_dec;
  logic                      hit;

  // Count up and compare against the period; wrap on a zero period
  assign elapsed_inc = rec.elapsed + ptt_pkg::CNT_W'(1);
  assign hit         = (elapsed_inc == rec.period);
  assign loops_dec   = rec.loops - ptt_pkg::CNT_W'(1);

  // Reload on a hit, drop one repeat, free the slot when repeats run out
  always_comb begin
    upd.fired      = hit;
    upd.elapsed    = hit ? '0 : elapsed_inc;
    upd.loops      = hit ? loops_dec : rec.loops;
    upd.keep       = (upd.loops != '0);
    upd.final_fire = hit && (loops_dec == '0);
  end

endmodule

`default_nettype wire

@@ rtl/core/periodic_timer_table.sv @@
// Periodic timer table: SLOTS timer slots swept by one shared update unit.
// Register and unregister: result shows in the cycle after the input beat;
// the next input is taken once that result leaves. Tick: the item is accepted,
// then each slot is read, each active slot updated and written back, each
// firing pushed and the sweep closed; output stalls hold the sweep. The final beat
// shows next and the next input is taken once it leaves. Reset (rst) frees all slots.
`default_nettype none

module periodic_timer_table #(
  parameter int SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // s_tdata: kind[1:0], timer_id[5:2], period[21:6], loop_count[37:22], zero pad
  input  wire logic [ptt_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // m_tdata: event_res[2:0], fired_id[6:3], zero pad
  output logic [ptt_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  // Input beat fields
  logic [ptt_pkg::KIND_W-1:0] kind;
  logic [ptt_pkg::ID_W-1:0]   timer_id;
  logic [ptt_pkg::CNT_W-1:0]  period;
  logic [ptt_pkg::CNT_W-1:0]  loop_count;
  logic [IDX_W-1:0]           id_idx;
  logic                       id_in_range;
  logic                       in_accept;
  logic                       out_free;

  assign kind       = s_tdata[1:0];
  assign timer_id   = s_tdata[5:2];
  assign period     = s_tdata[21:6];
  assign loop_count = s_tdata[37:22];
  assign id_idx     = IDX_W'(timer_id);
  assign id_in_range = ({{(32 - ptt_pkg::ID_W){1'b0}}, timer_id} < 32'(SLOTS));

  // Control and payload registers
  ptt_pkg::state_t            state, state_next;
  logic [IDX_W-1:0]           slot, slot_next;
  logic [SLOTS-1:0]           valid, valid_next;
  logic                       out_valid, out_valid_next;
  logic [ptt_pkg::EV_W-1:0]   out_ev, out_ev_next;
  logic [ptt_pkg::ID_W-1:0]   out_id, out_id_next;
  logic                       out_last, out_last_next;
  logic                       pend_valid, pend_valid_next;
  logic [ptt_pkg::ID_W-1:0]   pend_id, pend_id_next;
  logic                       pend_final, pend_final_next;
  logic [ptt_pkg::ID_W-1:0]   cur_id, cur_id_next;
  logic                       cur_final, cur_final_next;

  // Slot memory ports
  ptt_pkg::slot_rec_t         mem [SLOTS];
  ptt_pkg::slot_rec_t         rd_data;
  ptt_pkg::slot_rec_t         mem_wdata;
  logic [IDX_W-1:0]           mem_waddr;
  logic                       mem_we;
  ptt_pkg::upd_t              upd;

  assign s_tready  = (state == ptt_pkg::ST_IDLE) && !out_valid;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_id, out_ev};
  assign m_tlast  = out_last;

  // Shared update unit
  ptt_slot_alu u_alu (
    .rec (rd_data),
    .upd (upd)
  );

  // Write one slot per cycle when enabled, read the swept slot with a registered output
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[slot];
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next      = state;
    slot_next       = slot;
    valid_next      = valid;
    out_valid_next  = out_valid && !m_tready;
    out_ev_next     = out_ev;
    out_id_next     = out_id;
    out_last_next   = out_last;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    pend_final_next = pend_final;
    cur_id_next     = cur_id;
    cur_final_next  = cur_final;
    mem_we          = 1'b0;
    mem_waddr       = slot;
    mem_wdata       = '{period: upd.elapsed, elapsed: upd.elapsed, loops: upd.loops};
    mem_wdata.period = rd_data.period;

    unique case (state)
      ptt_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (kind == ptt_pkg::KIND_REG) begin
            out_valid_next = 1'b1;
            out_id_next    = timer_id;
            out_last_next  = 1'b1;
            if (id_in_range && !valid[id_idx]) begin
              valid_next[id_idx] = 1'b1;
              mem_we      = 1'b1;
              mem_waddr   = id_idx;
              mem_wdata   = '{period: period, elapsed: '0, loops: loop_count};
              out_ev_next = ptt_pkg::EV_REGISTERED;
            end else begin
              out_ev_next = ptt_pkg::EV_DUPLICATE;
            end
          end else if (kind == ptt_pkg::KIND_UNREG) begin
            out_valid_next = 1'b1;
            out_id_next    = timer_id;
            out_last_next  = 1'b1;
            if (id_in_range && valid[id_idx]) begin
              valid_next[id_idx] = 1'b0;
              out_ev_next = ptt_pkg::EV_REMOVED;
            end else begin
              out_ev_next = ptt_pkg::EV_NOT_FOUND;
            end
          end else if (kind == ptt_pkg::KIND_TICK) begin
            slot_next       = '0;
            pend_valid_next = 1'b0;
            state_next      = ptt_pkg::ST_READ;
          end
        end
      end

      // Skip free slots; the read of an active slot lands next cycle
      ptt_pkg::ST_READ: begin
        if (valid[slot]) begin
          state_next = ptt_pkg::ST_UPDATE;
        end else if (slot == LAST_SLOT) begin
          state_next = ptt_pkg::ST_DONE;
        end else begin
          slot_next  = slot + IDX_W'(1);
        end
      end

      // Write back the advanced record and hold a firing for output
      ptt_pkg::ST_UPDATE: begin
        mem_we = 1'b1;
        if (!upd.keep) begin
          valid_next[slot] = 1'b0;
        end
        if (upd.fired) begin
          cur_id_next    = ptt_pkg::ID_W'(slot);
          cur_final_next = upd.final_fire;
          state_next     = ptt_pkg::ST_PUSH;
        end else if (slot == LAST_SLOT) begin
          state_next = ptt_pkg::ST_DONE;
        end else begin
          slot_next  = slot + IDX_W'(1);
          state_next = ptt_pkg::ST_READ;
        end
      end

      // Release the previous firing (not last) and park the new one
      ptt_pkg::ST_PUSH: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_id_next    = pend_id;
            out_ev_next    = pend_final ? ptt_pkg::EV_FIRED_LAST : ptt_pkg::EV_FIRED;
            out_last_next  = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_id_next    = cur_id;
          pend_final_next = cur_final;
          if (slot == LAST_SLOT) begin
            state_next = ptt_pkg::ST_DONE;
          end else begin
            slot_next  = slot + IDX_W'(1);
            state_next = ptt_pkg::ST_READ;
          end
        end
      end

      // Close the tick with the last firing or a quiet beat
      ptt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_last_next   = 1'b1;
          if (pend_valid) begin
            out_id_next = pend_id;
            out_ev_next = pend_final ? ptt_pkg::EV_FIRED_LAST : ptt_pkg::EV_FIRED;
          end else begin
            out_id_next = '0;
            out_ev_next = ptt_pkg::EV_QUIET;
          end
          pend_valid_next = 1'b0;
          state_next      = ptt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptt_pkg::ST_IDLE;
      valid      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      slot       <= '0;
    end else begin
      state      <= state_next;
      valid      <= valid_next;
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
      slot       <= slot_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_ev     <= out_ev_next;
    out_id     <= out_id_next;
    out_last   <= out_last_next;
    pend_id    <= pend_id_next;
    pend_final <= pend_final_next;
    cur_id     <= cur_id_next;
    cur_final  <= cur_final_next;
  end

endmodule

`default_nettype wire

@@ verif/periodic_timer_table_check.sv @@
// Checker for the periodic timer table: follows the input and result beats,
// keeps its own copy of the slot table and compares each result beat in order.
// Depends on ptt_pkg for field widths, item kinds and result codes.

module periodic_timer_table_check #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [39:0] s_tdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  output int               mismatches,
  output int               outstanding
);
  import ptt_pkg::*;

  typedef struct {
    logic [EV_W-1:0] ev;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_event_t;

  // Expected result beats, oldest first
  timer_event_t event_q[$];

  // Shadow slot table
  logic             slot_live    [SLOTS];
  logic [CNT_W-1:0] slot_period  [SLOTS];
  logic [CNT_W-1:0] slot_count   [SLOTS];
  logic [CNT_W-1:0] slot_repeats [SLOTS];

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Append one expected beat at the tail of the queue
  task automatic expect_beat(input timer_event_t e);
    event_q = {event_q, e};
  endtask

  function automatic timer_event_t make_event(input logic [EV_W-1:0] ev,
                                              input logic [ID_W-1:0] id,
                                              input logic last);
    timer_event_t e;
    e.ev   = ev;
    e.id   = id;
    e.last = last;
    return e;
  endfunction

  // Apply one accepted input beat to the shadow table and queue its results
  task automatic advance_table(input logic [39:0] beat);
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  per;
    logic [CNT_W-1:0]  reps;
    timer_event_t      held;
    bit                have_held;
    kind      = beat[1:0];
    id        = beat[5:2];
    per       = beat[21:6];
    reps      = beat[37:22];
    have_held = 0;
    case (kind)
      KIND_REG: begin
        if (int'(id) >= SLOTS || slot_live[id]) begin
          expect_beat(make_event(EV_DUPLICATE, id, 1'b1));
        end else begin
          slot_live[id]    = 1'b1;
          slot_period[id]  = per;
          slot_count[id]   = '0;
          slot_repeats[id] = reps;
          expect_beat(make_event(EV_REGISTERED, id, 1'b1));
        end
      end
      KIND_UNREG: begin
        if (int'(id) < SLOTS && slot_live[id]) begin
          slot_live[id] = 1'b0;
          expect_beat(make_event(EV_REMOVED, id, 1'b1));
        end else begin
          expect_beat(make_event(EV_NOT_FOUND, id, 1'b1));
        end
      end
      KIND_TICK: begin
        // Sweep slots in ascending order; hold back the newest firing so
        // that the final one can carry last
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_live[s]) begin
            slot_count[s] = slot_count[s] + 1'b1;
            if (slot_count[s] == slot_period[s]) begin
              slot_count[s]   = '0;
              slot_repeats[s] = slot_repeats[s] - 1'b1;
              if (have_held) expect_beat(held);
              held      = make_event(slot_repeats[s] == '0 ? EV_FIRED_LAST : EV_FIRED,
                                     ID_W'(s), 1'b0);
              have_held = 1;
            end
            if (slot_repeats[s] == '0) slot_live[s] = 1'b0;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expect_beat(held);
        end else begin
          expect_beat(make_event(EV_QUIET, '0, 1'b1));
        end
      end
      default: begin
        // undefined kind: dropped by the block, nothing expected
      end
    endcase
  endtask

  // Predict on input beats, then compare result beats against the queue
  always @(posedge clk) begin
    timer_event_t want;
    logic [EV_W-1:0] got_ev;
    logic [ID_W-1:0] got_id;
    got_ev = m_tdata[2:0];
    got_id = m_tdata[6:3];
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) slot_live[s] = 1'b0;
      event_q.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) advance_table(s_tdata);
      if (m_tvalid && m_tready) begin
        if (event_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result beat: ev %0d id %0d last %0b",
                                  got_ev, got_id, m_tlast));
        end else begin
          want = event_q.pop_front();
          if (got_ev !== want.ev || got_id !== want.id || m_tlast !== want.last)
            note_mismatch($sformatf(
              "result mismatch: expected ev %0d id %0d last %0b, got ev %0d id %0d last %0b",
              want.ev, want.id, want.last, got_ev, got_id, m_tlast));
        end
      end
    end
    outstanding <= event_q.size();
  end

endmodule

@@ verif/periodic_timer_table_test.sv @@
// Testbench top for the periodic timer table: clock, reset, directed and
// random input beats, random result backpressure and the final verdict.
// Depends on ptt_pkg, periodic_timer_table and periodic_timer_table_check.

module periodic_timer_table_test;
  import ptt_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 370;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [39:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int items = 0;
  bit steady = 1'b0;

  always #2 clk = ~clk;

  periodic_timer_table #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  periodic_timer_table_check #(.SLOTS(SLOTS)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Stall the result side at random unless in a steady stretch
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one input beat and hold it until accepted
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic [CNT_W-1:0] per, input logic [CNT_W-1:0] reps);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, reps, per, id, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind != KIND_UNUSED) items++;
  endtask

  initial begin
    int pick;
    logic [CNT_W-1:0] per;
    logic [CNT_W-1:0] reps;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, duplicates, zero period and zero repeats
    send_beat(KIND_TICK, 4'd0, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_UNREG, 4'd5, 16'd0, 16'd0);
    send_beat(KIND_REG, 4'd0, 16'd1, 16'd1);
    send_beat(KIND_REG, 4'd0, 16'd3, 16'd3);
    send_beat(KIND_REG, 4'd15, 16'd1, 16'd0);
    send_beat(KIND_REG, 4'd7, 16'd0, 16'd3);
    send_beat(KIND_REG, 4'd3, 16'd2, 16'd0);
    send_beat(KIND_REG, 4'd9, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_REG, 4'd1, 16'd2, 16'd2);
    send_beat(KIND_TICK, 4'd15, 16'd0, 16'd0);
    send_beat(KIND_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(KIND_UNREG, 4'd3, 16'd0, 16'd0);
    send_beat(KIND_UNREG, 4'd0, 16'd0, 16'd0);
    send_beat(KIND_UNREG, 4'd15, 16'd0, 16'd0);
    send_beat(KIND_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(KIND_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(KIND_UNREG, 4'd7, 16'd0, 16'd0);
    send_beat(KIND_UNREG, 4'd9, 16'd0, 16'd0);

    // Random: mostly short timers so slots fire and retire often
    items = 0;
    while (items < RANDOM_ITEMS) begin
      steady = (items >= 100 && items < 200);
      pick = $urandom_range(99);
      if (pick < 4) begin
        // Refill the whole table with fast timers, then tick it
        for (int s = 0; s < SLOTS; s++)
          send_beat(KIND_UNREG, ID_W'(s), CNT_W'($urandom), CNT_W'($urandom));
        for (int s = 0; s < SLOTS; s++)
          send_beat(KIND_REG, ID_W'(s), CNT_W'($urandom_range(1, 2)),
                    CNT_W'($urandom_range(1, 3)));
        repeat (3)
          send_beat(KIND_TICK, ID_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      end else if (pick < 50) begin
        send_beat(KIND_TICK, ID_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      end else if (pick < 78) begin
        pick = $urandom_range(99);
        per  = pick < 75 ? CNT_W'($urandom_range(1, 6)) : (pick < 85 ? '0 : CNT_W'($urandom));
        pick = $urandom_range(99);
        reps = pick < 70 ? CNT_W'($urandom_range(1, 4)) : (pick < 80 ? '0 : CNT_W'($urandom));
        send_beat(KIND_REG, ID_W'($urandom), per, reps);
      end else if (pick < 95) begin
        send_beat(KIND_UNREG, ID_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      end else begin
        send_beat(KIND_UNUSED, ID_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
      end
    end
    steady = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain the result queue, then allow a full sweep for stray beats
    do @(posedge clk); while (outstanding != 0);
    repeat (3 * SLOTS + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
